@@ src/sqltok_pkg.sv @@
// Shared types, token kind codes and the keyword table for the SQL token stream.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sqltok_pkg;

	localparam int unsigned POS_BITS_DEF = 16;
	localparam int unsigned KIND_W       = 5;
	localparam int unsigned LEN_W        = 16;
	localparam int unsigned MAX_TOK      = 3;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned OUT_TDATA_W  = 40;
	localparam int unsigned KW_COUNT     = 16;

	localparam logic [KIND_W-1:0] KIND_EOF     = 5'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd1;
	localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd2;
	localparam logic [KIND_W-1:0] KIND_STRING  = 5'd3;
	localparam logic [KIND_W-1:0] KIND_KEY0    = 5'd4;
	localparam logic [KIND_W-1:0] KIND_STAR    = 5'd20;
	localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd21;
	localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd22;
	localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd23;
	localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd24;
	localparam logic [KIND_W-1:0] KIND_EQ      = 5'd25;
	localparam logic [KIND_W-1:0] KIND_GT      = 5'd26;
	localparam logic [KIND_W-1:0] KIND_LT      = 5'd27;
	localparam logic [KIND_W-1:0] KIND_GE      = 5'd28;
	localparam logic [KIND_W-1:0] KIND_LE      = 5'd29;
	localparam logic [KIND_W-1:0] KIND_DOT     = 5'd30;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd31;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// Keywords, right-justified and zero-filled like the running prefix.
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "CREATE", "TABLE",
		"INNER", "JOIN", "ON", "DELETE", "ORDER", "BY", "ASC", "DESC"
	};

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  start;
		logic [KIND_W-1:0] kind;
	} tok_t;

	// Tokens caused by one input byte, oldest in slot 0.
	typedef struct packed {
		logic [1:0]           count;
		tok_t [MAX_TOK-1:0]   tok;
	} bundle_t;

	function automatic logic [KIND_W-1:0] ident_kind(input logic [LEN_W-1:0] len,
			input logic [47:0] prefix);
		logic [KIND_W-1:0] k;
		k = KIND_IDENT;
		if (len >= 16'd2 && len <= 16'd6) begin
			for (int i = 0; i < KW_COUNT; i++) begin
				if (prefix == KW_TEXT[i])
					k = KIND_KEY0 + KIND_W'(i);
			end
		end
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] symbol_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CH_STAR:   k = KIND_STAR;
			CH_COMMA:  k = KIND_COMMA;
			CH_SEMI:   k = KIND_SEMI;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_EQ:     k = KIND_EQ;
			CH_DOT:    k = KIND_DOT;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

@@ src/sqltok_front.sv @@
// Front end: lexer state machine, one byte per beat, bundles up to three tokens.
// Depends on sqltok_pkg.
`default_nettype none

module sqltok_front #(
	parameter int unsigned POS_BITS = sqltok_pkg::POS_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [7:0]           char_byte,
	input  wire                  end_of_text,
	input  wire                  accept,
	output logic                 push,
	output sqltok_pkg::bundle_t  bundle
);
	import sqltok_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_GT, M_LT, M_DONE
	} mode_t;

	mode_t               mode_q;
	logic [POS_BITS-1:0] pos_q;
	logic [POS_BITS-1:0] start_q;
	logic [LEN_W-1:0]    len_q;
	logic [47:0]         prefix_q;

	mode_t               md;
	logic [POS_BITS-1:0] st;
	logic [LEN_W-1:0]    ln;
	logic [47:0]         pf;
	logic [POS_BITS-1:0] p1;
	logic [1:0]          n;
	logic                run_idle;
	tok_t [MAX_TOK-1:0]  tk;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic tok_t mk_tok(input logic [KIND_W-1:0] k,
			input logic [POS_BITS-1:0] s, input logic [LEN_W-1:0] l);
		tok_t t;
		t.kind  = k;
		t.start = LEN_W'(s);
		t.len   = l;
		return t;
	endfunction

	function automatic logic has_tok(input mode_t m);
		return m == M_IDENT || m == M_NUMBER || m == M_STRING || m == M_GT || m == M_LT;
	endfunction

	// Token held open in mode m, closed without further input.
	function automatic tok_t flush_tok(input mode_t m, input logic [POS_BITS-1:0] s,
			input logic [LEN_W-1:0] l, input logic [47:0] pre);
		tok_t t;
		t = mk_tok(KIND_IDENT, s, l);
		case (m)
			M_IDENT:  t.kind = ident_kind(l, pre);
			M_NUMBER: t.kind = KIND_NUMBER;
			M_STRING: t.kind = KIND_STRING;
			M_GT:     t = mk_tok(KIND_GT, s, 16'd1);
			M_LT:     t = mk_tok(KIND_LT, s, 16'd1);
			default:  t = mk_tok(KIND_EOF, s, l);
		endcase
		return t;
	endfunction

	always_comb begin
		md       = mode_q;
		st       = start_q;
		ln       = len_q;
		pf       = prefix_q;
		p1       = pos_q + 1'b1;
		n        = 2'd0;
		run_idle = 1'b0;
		tk       = '0;

		// Continue or close the token in progress.
		unique case (mode_q)
			M_IDENT: begin
				if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == CH_UNDER) begin
					ln = sat_inc(ln);
					pf = {pf[39:0], to_upper(char_byte)};
				end else begin
					tk[n]    = flush_tok(mode_q, st, ln, pf);
					n        = n + 2'd1;
					md       = M_IDLE;
					run_idle = 1'b1;
				end
			end
			M_NUMBER: begin
				if (is_digit(char_byte) || char_byte == CH_DOT) begin
					ln = sat_inc(ln);
				end else begin
					tk[n]    = flush_tok(mode_q, st, ln, pf);
					n        = n + 2'd1;
					md       = M_IDLE;
					run_idle = 1'b1;
				end
			end
			M_STRING: begin
				if (char_byte == CH_QUOTE) begin
					tk[n] = flush_tok(mode_q, st, ln, pf);
					n     = n + 2'd1;
					md    = M_IDLE;
				end else if (char_byte != CH_NUL) begin
					ln = sat_inc(ln);
				end else begin
					tk[n]    = flush_tok(mode_q, st, ln, pf);
					n        = n + 2'd1;
					md       = M_IDLE;
					run_idle = 1'b1;
				end
			end
			M_GT, M_LT: begin
				if (char_byte == CH_EQ) begin
					tk[n] = mk_tok((mode_q == M_GT) ? KIND_GE : KIND_LE, st, 16'd2);
					n     = n + 2'd1;
					md    = M_IDLE;
				end else begin
					tk[n]    = flush_tok(mode_q, st, ln, pf);
					n        = n + 2'd1;
					md       = M_IDLE;
					run_idle = 1'b1;
				end
			end
			M_IDLE: run_idle = 1'b1;
			M_DONE: begin
			end
		endcase

		// Byte seen with no token open.
		if (run_idle) begin
			priority if (char_byte == CH_NUL) begin
				tk[n] = mk_tok(KIND_EOF, pos_q, '0);
				n     = n + 2'd1;
				md    = M_DONE;
			end else if (is_space(char_byte)) begin
			end else if (is_alpha(char_byte)) begin
				md = M_IDENT;
				st = pos_q;
				ln = 16'd1;
				pf = {40'd0, to_upper(char_byte)};
			end else if (is_digit(char_byte)) begin
				md = M_NUMBER;
				st = pos_q;
				ln = 16'd1;
				pf = '0;
			end else if (char_byte == CH_QUOTE) begin
				md = M_STRING;
				st = p1;
				ln = '0;
				pf = '0;
			end else if (char_byte == CH_GT) begin
				md = M_GT;
				st = pos_q;
				ln = '0;
				pf = '0;
			end else if (char_byte == CH_LT) begin
				md = M_LT;
				st = pos_q;
				ln = '0;
				pf = '0;
			end else begin
				tk[n] = mk_tok(symbol_kind(char_byte), pos_q, 16'd1);
				n     = n + 2'd1;
			end
		end

		// End of text marker: close what is open, then EOF just past this byte.
		if (end_of_text && mode_q != M_DONE && md != M_DONE) begin
			if (has_tok(md)) begin
				tk[n] = flush_tok(md, st, ln, pf);
				n     = n + 2'd1;
			end
			tk[n] = mk_tok(KIND_EOF, p1, '0);
			n     = n + 2'd1;
		end
	end

	assign bundle.count = n;
	assign bundle.tok   = tk;
	assign push         = accept && n != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q   <= M_IDLE;
				pos_q    <= '0;
				start_q  <= '0;
				len_q    <= '0;
				prefix_q <= '0;
			end else begin
				mode_q   <= md;
				if (mode_q != M_DONE)
					pos_q <= p1;
				start_q  <= st;
				len_q    <= ln;
				prefix_q <= pf;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/sqltok_queue.sv @@
// Short queue of token bundles between the lexer front end and the output side.
// Depends on sqltok_pkg.
`default_nettype none

module sqltok_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire sqltok_pkg::bundle_t wr_bundle,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output sqltok_pkg::bundle_t  head
);
	import sqltok_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	bundle_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/sqltok_back.sv @@
// Back end: unpacks queued bundles into one token per beat through an output register.
// Depends on sqltok_pkg.
`default_nettype none

module sqltok_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  wire sqltok_pkg::bundle_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output sqltok_pkg::tok_t     out_tok
);
	import sqltok_pkg::*;

	logic       vld_q;
	logic [1:0] sel_q;
	tok_t       tok_q;
	logic       load;
	logic       last_sel;

	assign load      = head_valid && (!vld_q || out_ready);
	assign last_sel  = sel_q == head.count - 2'd1;
	assign pop       = load && last_sel;
	assign out_valid = vld_q;
	assign out_tok   = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			sel_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				sel_q <= last_sel ? 2'd0 : sel_q + 2'd1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			tok_q <= head.tok[sel_q];
	end

endmodule

`default_nettype wire

@@ src/sql_lexer_token_stream.sv @@
// Top level of the SQL token stream: lexer front end, bundle queue, token output side.
// Depends on sqltok_pkg, sqltok_front, sqltok_queue and sqltok_back.
`default_nettype none

// SQL text goes in one byte per beat on the s_ side; token descriptors come out
// one per beat on the m_ side. The lexer takes a byte every cycle while its
// bundle queue (four entries) has room, and keeps taking bytes while a token
// waits at the output. One byte can close up to three tokens at once (a pending
// token, a symbol, and the EOF of a marked last byte); those go into one queue
// entry and leave one token per cycle while m_tready is high. So the sustained
// rate is one byte per cycle as long as the text yields no more than one token
// per byte on average and m_tready stays high; the single token output register
// sets that limit. A NUL byte ends the statement with an EOF token and later
// bytes are dropped up to the one marked tlast. Token offsets wrap at 2^POS_BITS
// and are shown in 16 bits; lengths saturate at 65535.
module sql_lexer_token_stream #(
	parameter int unsigned POS_BITS = sqltok_pkg::POS_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [7:0]   s_tdata,   // [7:0] char_byte
	input  wire          s_tlast,   // end_of_text
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [sqltok_pkg::OUT_TDATA_W-1:0] m_tdata, // [4:0] token_kind,
	                                // [20:5] token_start, [36:21] token_length,
	                                // [39:37] zero
	output logic         m_tlast    // final_token
);
	import sqltok_pkg::*;

	logic    accept;
	logic    q_push;
	logic    q_full;
	logic    q_pop;
	logic    q_head_valid;
	bundle_t q_wr;
	bundle_t q_head;
	tok_t    out_tok;

	// A beat is taken whenever the queue can hold another bundle.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	sqltok_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_byte   (s_tdata),
		.end_of_text (s_tlast),
		.accept      (accept),
		.push        (q_push),
		.bundle      (q_wr)
	);

	sqltok_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_bundle  (q_wr),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	sqltok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_tok    (out_tok)
	);

	// Output beat: kind, start, length packed from bit 0 up.
	assign m_tdata = {3'b000, out_tok.len, out_tok.start, out_tok.kind};
	assign m_tlast = out_tok.kind == KIND_EOF;

`ifndef SYNTH
	// The queue never takes a bundle it has no room for.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("bundle pushed into full queue");

	// Only bundles that carry tokens are queued.
	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_wr.count != 2'd0)
		else $error("empty bundle queued");

	// A final token is an EOF of zero length.
	a_eof_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[36:21] == 16'd0)
		else $error("EOF token with nonzero length");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for sql_lexer_token_stream: feeds SQL text beats and checks token beats
// against a built-in lexer model. Depends on sqltok_pkg and the RTL under src/.

module testbench;
	import sqltok_pkg::*;

	typedef enum logic [2:0] {
		LX_IDLE, LX_WORD, LX_NUM, LX_STR, LX_GT, LX_LT, LX_DONE
	} lex_mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        is_eof;
	} token_t;

	localparam logic [47:0] KEYWORDS [16] = '{
		"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "CREATE", "TABLE",
		"INNER", "JOIN", "ON", "DELETE", "ORDER", "BY", "ASC", "DESC"
	};
	localparam logic [7:0] PUNCT [7] = '{
		CH_STAR, CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_EQ, CH_DOT
	};
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// lexer model state
	lex_mode_t   lex_mode;
	logic [15:0] lex_pos;
	logic [15:0] tok_start;
	logic [15:0] tok_len;
	logic [47:0] kw_shift;

	token_t      pending_tokens[$];
	logic [7:0]  stmt[$];
	int          mismatches    = 0;
	int          handled_bytes = 0;
	int          burst_left    = 0;
	bit          gaps_on       = 1'b1;
	bit          hold_request  = 1'b0;
	int          hold_left     = 0;
	int          rx_left       = 0;
	int          rx_style      = 0;

	sql_lexer_token_stream dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Lexer model
	// ---------------------------------------------------------------
	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// Keyword match only for 2..6 chars; kw_shift holds the last six, upper-cased.
	function automatic logic [4:0] word_kind();
		logic [4:0] k;
		k = KIND_IDENT;
		if (tok_len >= 16'd2 && tok_len <= 16'd6) begin
			for (int i = 0; i < 16; i++)
				if (kw_shift == KEYWORDS[i])
					k = KIND_KEY0 + 5'(i);
		end
		return k;
	endfunction

	function automatic logic [4:0] single_kind(input logic [7:0] c);
		case (c)
			CH_STAR:   return KIND_STAR;
			CH_COMMA:  return KIND_COMMA;
			CH_SEMI:   return KIND_SEMI;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			CH_EQ:     return KIND_EQ;
			CH_DOT:    return KIND_DOT;
			default:   return KIND_UNKNOWN;
		endcase
	endfunction

	task automatic push_token(input logic [4:0] kind, input logic [15:0] start,
			input logic [15:0] len);
		token_t t;
		t.kind   = kind;
		t.start  = start;
		t.len    = len;
		t.is_eof = (kind == KIND_EOF);
		pending_tokens.insert(pending_tokens.size(), t);
	endtask

	task automatic lexer_restart();
		lex_mode  = LX_IDLE;
		lex_pos   = '0;
		tok_start = '0;
		tok_len   = '0;
		kw_shift  = '0;
	endtask

	task automatic open_token(input lex_mode_t m, input logic [15:0] s);
		lex_mode  = m;
		tok_start = s;
		tok_len   = '0;
		kw_shift  = '0;
	endtask

	// emit whatever token is in progress, back to idle
	task automatic close_token();
		case (lex_mode)
			LX_WORD: push_token(word_kind(), tok_start, tok_len);
			LX_NUM:  push_token(KIND_NUMBER, tok_start, tok_len);
			LX_STR:  push_token(KIND_STRING, tok_start, tok_len);
			LX_GT:   push_token(KIND_GT, tok_start, 16'd1);
			LX_LT:   push_token(KIND_LT, tok_start, 16'd1);
			default: ;
		endcase
		lex_mode = LX_IDLE;
	endtask

	task automatic idle_char(input logic [7:0] c, input logic [15:0] p);
		if (c == CH_NUL) begin
			push_token(KIND_EOF, p, 16'd0);
			lex_mode = LX_DONE;
		end else if (is_blank(c)) begin
		end else if (is_letter(c)) begin
			open_token(LX_WORD, p);
			tok_len  = 16'd1;
			kw_shift = {40'd0, upcase(c)};
		end else if (is_digit(c)) begin
			open_token(LX_NUM, p);
			tok_len = 16'd1;
		end else if (c == CH_QUOTE) begin
			open_token(LX_STR, p + 16'd1);     // value starts after the quote
		end else if (c == CH_GT) begin
			open_token(LX_GT, p);
		end else if (c == CH_LT) begin
			open_token(LX_LT, p);
		end else begin
			push_token(single_kind(c), p, 16'd1);
		end
	endtask

	task automatic extend();
		if (tok_len != 16'hFFFF)
			tok_len++;
	endtask

	task automatic next_char(input logic [7:0] c, input logic [15:0] p);
		case (lex_mode)
			LX_WORD: begin
				if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
					extend();
					kw_shift = {kw_shift[39:0], upcase(c)};
					return;
				end
				close_token();
			end
			LX_NUM: begin
				if (is_digit(c) || c == CH_DOT) begin
					extend();
					return;
				end
				close_token();
			end
			LX_STR: begin
				if (c == CH_QUOTE) begin
					close_token();
					return;
				end
				if (c != CH_NUL) begin
					extend();
					return;
				end
				close_token();
			end
			LX_GT, LX_LT: begin
				if (c == CH_EQ) begin
					push_token(lex_mode == LX_GT ? KIND_GE : KIND_LE, tok_start, 16'd2);
					lex_mode = LX_IDLE;
					return;
				end
				close_token();
			end
			default: ;
		endcase
		idle_char(c, p);
	endtask

	// Model step for one accepted text beat.
	task automatic predict_beat(input logic [7:0] c, input logic last);
		logic [15:0] p;
		p = lex_pos;
		if (lex_mode != LX_DONE) begin
			handled_bytes++;
			next_char(c, p);
			lex_pos = p + 16'd1;
			if (last && lex_mode != LX_DONE) begin
				close_token();
				push_token(KIND_EOF, lex_pos, 16'd0);
			end
		end
		if (last)
			lexer_restart();
	endtask

	// ---------------------------------------------------------------
	// Text side
	// ---------------------------------------------------------------
	// Offers one beat; valid stays high afterwards until the next beat or stop_sending.
	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 25)
				                                   : $urandom_range(1, 4);
				repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
			end
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_beat(c, last);
	endtask

	task automatic stop_sending();
		@(negedge clk) s_tvalid <= 1'b0;
	endtask

	task automatic send_text(input bit mark_last);
		foreach (stmt[i])
			send_byte(stmt[i], mark_last && i == stmt.size() - 1);
	endtask

	// appends one byte to the statement being built
	task automatic add_char(input logic [7:0] c);
		stmt.insert(stmt.size(), c);
	endtask

	task automatic load_text(input string s);
		stmt.delete();
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic wait_drained();
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] any_letter();
		logic [7:0] c;
		c = 8'("a" + $urandom_range(0, 25));
		return $urandom_range(0, 1) ? c - 8'd32 : c;
	endfunction

	// string content: anything but the quote and NUL
	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
		return c;
	endfunction

	// Random statement body: mostly well-formed tokens, some noise bytes.
	task automatic build_statement();
		logic [47:0] w;
		int          n;
		stmt.delete();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
				0: begin
					w = KEYWORDS[$urandom_range(0, 15)];
					for (int b = 5; b >= 0; b--)
						if (w[b*8 +: 8] != 8'd0)
							add_char($urandom_range(0, 1) ? w[b*8 +: 8] + 8'd32
							                              : w[b*8 +: 8]);
				end
				1: begin
					add_char(any_letter());
					n = $urandom_range(0, 7);
					repeat (n) begin
						case ($urandom_range(0, 2))
							0:       add_char(any_letter());
							1:       add_char(8'("0" + $urandom_range(0, 9)));
							default: add_char(CH_UNDER);
						endcase
					end
				end
				2: begin
					add_char(8'("0" + $urandom_range(0, 9)));
					repeat ($urandom_range(0, 5))
						add_char(($urandom_range(0, 4) == 0) ? CH_DOT
						         : 8'("0" + $urandom_range(0, 9)));
				end
				3: begin
					add_char(CH_QUOTE);
					repeat ($urandom_range(0, 6))
						add_char(text_char());
					if ($urandom_range(0, 9) != 0)
						add_char(CH_QUOTE);
				end
				4: add_char(PUNCT[$urandom_range(0, 6)]);
				5: begin
					add_char($urandom_range(0, 1) ? CH_GT : CH_LT);
					if ($urandom_range(0, 1))
						add_char(CH_EQ);
				end
				6, 7: repeat ($urandom_range(1, 2))
					add_char(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13))
					                                     : 8'h20);
				8: add_char(8'($urandom_range(1, 255)));
				default: add_char(8'($urandom_range(128, 255)));
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// Token side: stall pattern, with a long hold-off on request
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_left  = $urandom_range(8, 64);
			end
			rx_left--;
			case (rx_style)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= rx_left[2];
			endcase
		end
	end

	// Each token beat against the oldest predicted token.
	always @(posedge clk) begin
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				$error("unexpected token beat: kind %0d start %0d length %0d",
				       m_tdata[4:0], m_tdata[20:5], m_tdata[36:21]);
				mismatches++;
			end else begin
				want = pending_tokens.pop_front();
				if (m_tdata[4:0] !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, m_tdata[4:0]);
					mismatches++;
				end
				if (m_tdata[20:5] !== want.start) begin
					$error("token_start: expected %0d, got %0d", want.start, m_tdata[20:5]);
					mismatches++;
				end
				if (m_tdata[36:21] !== want.len) begin
					$error("token_length: expected %0d, got %0d", want.len, m_tdata[36:21]);
					mismatches++;
				end
				if (m_tlast !== want.is_eof) begin
					$error("final_token: expected %0d, got %0d", want.is_eof, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// keyword in mixed case, 7-char ident ending in a keyword, 2-char keyword,
	// >= and <=, dotted number, bare > before a symbol, < pending at tlast
	task automatic test_directed_tokens();
		load_text("sElect xselect,oN>=1.5<=>*<");
		send_text(1'b1);
	endtask

	// NUL ends a statement, later bytes dropped up to tlast; NUL inside a
	// string; high bytes as unknown; remaining symbols; unterminated string;
	// empty and blank-only statements
	task automatic test_statement_ends();
		load_text("ab");
		send_text(1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte("z", 1'b0);
		send_byte("z", 1'b1);
		load_text("'x");
		send_text(1'b0);
		send_byte(CH_NUL, 1'b1);
		stmt.delete();
		stmt = '{8'hFF, 8'h80, 8'h09, CH_LPAREN, CH_RPAREN, CH_EQ, CH_SEMI, CH_DOT,
		         CH_QUOTE, "a", "b"};
		send_text(1'b1);
		send_byte(CH_NUL, 1'b1);
		send_byte(" ", 1'b1);
		stop_sending();
	endtask

	// Token side blocked for a long stretch while every byte makes a token:
	// the bundle queue fills and the text side must stall.
	task automatic test_output_holdoff();
		hold_request = 1'b1;
		for (int i = 0; i < 32; i++)
			send_byte(PUNCT[i % 7], i == 31);
		stop_sending();
	endtask

	// Random statements; sometimes the text side pauses until all tokens are out.
	task automatic test_random_statements();
		int first;
		int ending;
		first = handled_bytes;
		while (handled_bytes - first < 270) begin
			build_statement();
			ending = $urandom_range(0, 9);
			if (ending < 7) begin
				send_text(1'b1);
			end else begin
				send_text(1'b0);
				send_byte(CH_NUL, ending == 9);
				if (ending != 9) begin
					repeat ($urandom_range(0, 3))
						send_byte(8'($urandom_range(0, 255)), 1'b0);
					send_byte(8'($urandom_range(0, 255)), 1'b1);
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				stop_sending();
				wait_drained();
			end
		end
		stop_sending();
	endtask

	initial begin
		lexer_restart();
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_directed_tokens();
		test_statement_ends();
		test_output_holdoff();
		test_random_statements();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog: the slowest legal run is well under a fifth of this
	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
